// ----- sv/look_at_view_matrix_defines.svh -----
// Assertion helpers shared by the camera transform RTL.
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LAVM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LAVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/lavm_pkg.sv -----
package lavm_pkg;

  // Field and datapath widths.
  localparam int IN_W   = 32;
  localparam int OUT_W  = 16;
  localparam int VEC_W  = 64;
  localparam int MAG_W  = 63;
  localparam int SCL_W  = 31;
  localparam int ROOT_W = 32;
  localparam int IDX_W  = 6;

  // Position of the highest set bit; zero for an all-zero word.
  function automatic logic [IDX_W-1:0] msb_index(input logic [MAG_W-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ----- sv/lavm_norm.sv -----
module lavm_norm #(
  parameter int F = 14,
  parameter int SIDE_W = 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [lavm_pkg::VEC_W-1:0]  in_vec [3],
  input  logic [SIDE_W-1:0]                  in_side,
  output logic                               out_valid,
  output logic signed [F+1:0]                out_vec [3],
  output logic [SIDE_W-1:0]                  out_side
);
  import lavm_pkg::*;

  localparam int ND  = F + 1;
  localparam int NW  = SCL_W + F + 1;
  localparam int TOP = SCL_W - 1;
  localparam int SQ0 = 6;
  localparam int DV0 = SQ0 + ROOT_W + 1;
  localparam int LAT = DV0 + ND + 1;
  localparam int CW  = SIDE_W + 3;

  logic            valid [1:LAT];
  logic [CW-1:0]   ctl   [1:LAT];

  logic [MAG_W-1:0]     mag1 [3];
  logic [MAG_W-1:0]     mag2 [3];
  logic [MAG_W-1:0]     mag3 [3];
  logic [MAG_W-1:0]     mx2;
  logic [IDX_W-1:0]     p3;
  logic [SCL_W-1:0]     m4 [3];
  logic [SCL_W-1:0]     m5 [3];
  logic [2*SCL_W-1:0]   sq5 [3];

  logic [VEC_W-1:0]     sn    [0:ROOT_W];
  logic [ROOT_W+1:0]    srem  [0:ROOT_W];
  logic [ROOT_W-1:0]    sroot [0:ROOT_W];
  logic [SCL_W-1:0]     sm    [0:ROOT_W][3];
  logic [ROOT_W+1:0]    srem_next  [1:ROOT_W];
  logic [ROOT_W-1:0]    sroot_next [1:ROOT_W];

  logic [NW-1:0]        dn [0:ND][3];
  logic [ROOT_W-1:0]    dr [0:ND][3];
  logic [F:0]           dq [0:ND][3];
  logic [ROOT_W-1:0]    dd [0:ND];
  logic [ROOT_W-1:0]    dr_next [1:ND][3];
  logic [F:0]           dq_next [1:ND][3];
  logic [NW-1:0]        num0 [3];

  // Valid bits and control travel down the whole pipeline together.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= LAT; k++) begin
        valid[k] <= 1'b0;
      end
    end else if (en) begin
      valid[1] <= in_valid;
      for (int k = 2; k <= LAT; k++) begin
        valid[k] <= valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl[1] <= {in_side, in_vec[2][VEC_W-1], in_vec[1][VEC_W-1], in_vec[0][VEC_W-1]};
      for (int k = 2; k <= LAT; k++) begin
        ctl[k] <= ctl[k-1];
      end
    end
  end

  // Magnitudes, their maximum, the leading-one position, scaling and squares.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= in_vec[i][VEC_W-1] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
        mag2[i] <= mag1[i];
        mag3[i] <= mag2[i];
        if (p3 >= IDX_W'(TOP)) begin
          m4[i] <= SCL_W'(mag3[i] >> (p3 - IDX_W'(TOP)));
        end else begin
          m4[i] <= SCL_W'(mag3[i] << (IDX_W'(TOP) - p3));
        end
        m5[i]  <= m4[i];
        sq5[i] <= m4[i] * m4[i];
      end
      mx2 <= (mag1[0] > mag1[1]) ?
             ((mag1[0] > mag1[2]) ? mag1[0] : mag1[2]) :
             ((mag1[1] > mag1[2]) ? mag1[1] : mag1[2]);
      p3  <= msb_index(mx2);
    end
  end

  // Square root, two radicand bits per stage.
  always_comb begin
    logic [ROOT_W+3:0] x;
    logic [ROOT_W+3:0] trial;
    for (int k = 0; k < ROOT_W; k++) begin
      x     = {srem[k], sn[k][2*(ROOT_W-1-k) +: 2]};
      trial = (ROOT_W+4)'({sroot[k], 2'b01});
      if (x >= trial) begin
        srem_next[k+1]  = (ROOT_W+2)'(x - trial);
        sroot_next[k+1] = {sroot[k][ROOT_W-2:0], 1'b1};
      end else begin
        srem_next[k+1]  = (ROOT_W+2)'(x);
        sroot_next[k+1] = {sroot[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn[0]    <= VEC_W'(sq5[0]) + VEC_W'(sq5[1]) + VEC_W'(sq5[2]);
      srem[0]  <= '0;
      sroot[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        sm[0][i] <= m5[i];
      end
      for (int k = 1; k <= ROOT_W; k++) begin
        sn[k]    <= sn[k-1];
        srem[k]  <= srem_next[k];
        sroot[k] <= sroot_next[k];
        for (int i = 0; i < 3; i++) begin
          sm[k][i] <= sm[k-1][i];
        end
      end
    end
  end

  // Rounded division of each scaled component by the length, one quotient bit a stage.
  always_comb begin
    logic [ROOT_W:0] x;
    for (int i = 0; i < 3; i++) begin
      num0[i] = (NW'(sm[ROOT_W][i]) << F) + NW'(sroot[ROOT_W] >> 1);
    end
    for (int j = 0; j < ND; j++) begin
      for (int i = 0; i < 3; i++) begin
        x = {dr[j][i], dn[j][i][F-j]};
        if (x >= {1'b0, dd[j]}) begin
          dr_next[j+1][i] = ROOT_W'(x - {1'b0, dd[j]});
          dq_next[j+1][i] = {dq[j][i][F-1:0], 1'b1};
        end else begin
          dr_next[j+1][i] = ROOT_W'(x);
          dq_next[j+1][i] = {dq[j][i][F-1:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd[0] <= sroot[ROOT_W];
      for (int i = 0; i < 3; i++) begin
        dn[0][i] <= num0[i];
        dr[0][i] <= ROOT_W'(num0[i] >> (F + 1));
        dq[0][i] <= '0;
      end
      for (int j = 1; j <= ND; j++) begin
        dd[j] <= dd[j-1];
        for (int i = 0; i < 3; i++) begin
          dn[j][i] <= dn[j-1][i];
          dr[j][i] <= dr_next[j][i];
          dq[j][i] <= dq_next[j][i];
        end
      end
    end
  end

  // Sign restore; a zero length means a zero vector.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dd[ND] == '0) begin
          out_vec[i] <= '0;
        end else if (ctl[LAT-1][i]) begin
          out_vec[i] <= -$signed({1'b0, dq[ND][i]});
        end else begin
          out_vec[i] <= $signed({1'b0, dq[ND][i]});
        end
      end
    end
  end

  assign out_valid = valid[LAT];
  assign out_side  = ctl[LAT][CW-1:3];

endmodule

// ----- sv/look_at_view_matrix.sv -----
// Camera view-matrix builder.
// Input channel: in_valid / in_stall carry one transaction of eye position, viewing
// direction and up hint, all signed Q16.16. Output channel: out_valid / out_stall
// carry the right, true up and forward unit vectors in Q2.UNIT_FRAC_BITS (low 16
// bits) and the three saturated Q16.16 translation terms.
// Throughput is one transaction per cycle unless a valid result is stalled. The
// pipeline holds two normalizers (forward, then right): each runs a 32-stage
// square root and a (UNIT_FRAC_BITS + 1)-stage divider, one bit per stage.
// A zero direction gives all-zero outputs; a direction parallel to the up hint
// gives zero right and true up vectors.
// When the receiver stalls a valid result, the whole pipeline holds and in_stall
// rises in the same cycle; nothing is dropped or repeated. Synchronous reset
// clears every valid bit, so no transaction is in flight after reset.
`include "look_at_view_matrix_defines.svh"

module look_at_view_matrix #(
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [lavm_pkg::IN_W-1:0]    eye_x,
  input  logic signed [lavm_pkg::IN_W-1:0]    eye_y,
  input  logic signed [lavm_pkg::IN_W-1:0]    eye_z,
  input  logic signed [lavm_pkg::IN_W-1:0]    look_x,
  input  logic signed [lavm_pkg::IN_W-1:0]    look_y,
  input  logic signed [lavm_pkg::IN_W-1:0]    look_z,
  input  logic signed [lavm_pkg::IN_W-1:0]    hint_up_x,
  input  logic signed [lavm_pkg::IN_W-1:0]    hint_up_y,
  input  logic signed [lavm_pkg::IN_W-1:0]    hint_up_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lavm_pkg::OUT_W-1:0]   right_x,
  output logic signed [lavm_pkg::OUT_W-1:0]   right_y,
  output logic signed [lavm_pkg::OUT_W-1:0]   right_z,
  output logic signed [lavm_pkg::OUT_W-1:0]   camera_up_x,
  output logic signed [lavm_pkg::OUT_W-1:0]   camera_up_y,
  output logic signed [lavm_pkg::OUT_W-1:0]   camera_up_z,
  output logic signed [lavm_pkg::OUT_W-1:0]   forward_x,
  output logic signed [lavm_pkg::OUT_W-1:0]   forward_y,
  output logic signed [lavm_pkg::OUT_W-1:0]   forward_z,
  output logic signed [lavm_pkg::IN_W-1:0]    shift_right,
  output logic signed [lavm_pkg::IN_W-1:0]    shift_up,
  output logic signed [lavm_pkg::IN_W-1:0]    shift_forward
);
  import lavm_pkg::*;

  localparam int F   = UNIT_FRAC_BITS;
  localparam int UW  = F + 2;
  localparam int PW  = UW + IN_W;
  localparam int VW  = 2 * UW;
  localparam int S1W = 6 * IN_W;
  localparam int S2W = 3 * IN_W + 3 * UW;

  logic en;

  // Unit-vector rounding of a Q.2F cross term back to Q.F, clamped to one.
  function automatic logic signed [UW-1:0] round_unit(input logic signed [VW:0] d);
    logic [VW:0]   mag;
    logic [VW+1:0] r;
    logic [VW+1:0] x;
    mag = d[VW] ? (VW+1)'(-d) : (VW+1)'(d);
    r   = ({1'b0, mag} + ((VW+2)'(1) << (F - 1))) >> F;
    x   = (r > ((VW+2)'(1) << F)) ? ((VW+2)'(1) << F) : r;
    return d[VW] ? -$signed(UW'(x)) : $signed(UW'(x));
  endfunction

  // Negate, round to Q16.16 and saturate a translation sum.
  function automatic logic signed [IN_W-1:0] trans_fin(input logic signed [VEC_W-1:0] s);
    logic [VEC_W-1:0] mag;
    logic [VEC_W:0]   r;
    mag = s[VEC_W-1] ? VEC_W'(-s) : VEC_W'(s);
    r   = ({1'b0, mag} + ((VEC_W+1)'(1) << (F - 1))) >> F;
    if (s > 0) begin
      if (r > ((VEC_W+1)'(1) << (IN_W - 1))) begin
        return $signed({1'b1, {(IN_W-1){1'b0}}});
      end
      return $signed(IN_W'(0) - r[IN_W-1:0]);
    end
    if (r > (((VEC_W+1)'(1) << (IN_W - 1)) - (VEC_W+1)'(1))) begin
      return $signed({1'b0, {(IN_W-1){1'b1}}});
    end
    return $signed(r[IN_W-1:0]);
  endfunction

  // Global advance: the pipeline moves unless a result waits on a stalled receiver.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Forward vector.
  logic signed [VEC_W-1:0] dir_vec [3];
  logic [S1W-1:0]          side1_in;
  logic [S1W-1:0]          side1_out;
  logic signed [UW-1:0]    w_n1 [3];
  logic                    val_n1;

  assign dir_vec[0] = VEC_W'(look_x);
  assign dir_vec[1] = VEC_W'(look_y);
  assign dir_vec[2] = VEC_W'(look_z);
  assign side1_in   = {eye_x, eye_y, eye_z, hint_up_x, hint_up_y, hint_up_z};

  lavm_norm #(.F(F), .SIDE_W(S1W)) u_norm_fwd (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .in_vec(dir_vec), .in_side(side1_in),
    .out_valid(val_n1), .out_vec(w_n1), .out_side(side1_out)
  );

  logic signed [IN_W-1:0] up_n1 [3];
  assign up_n1[0] = $signed(side1_out[3*IN_W-1 -: IN_W]);
  assign up_n1[1] = $signed(side1_out[2*IN_W-1 -: IN_W]);
  assign up_n1[2] = $signed(side1_out[IN_W-1 -: IN_W]);

  // Cross product forward x up: products, then differences.
  logic                   val_c1, val_c2;
  logic signed [PW-1:0]   cp [6];
  logic signed [UW-1:0]   w_c1 [3];
  logic signed [UW-1:0]   w_c2 [3];
  logic [3*IN_W-1:0]      eye_c1, eye_c2;
  logic signed [PW:0]     cd [3];
  logic signed [VEC_W-1:0] t_c2 [3];

  assign cd[0] = cp[0] - cp[1];
  assign cd[1] = cp[2] - cp[3];
  assign cd[2] = cp[4] - cp[5];

  always_ff @(posedge clk) begin
    if (en) begin
      cp[0]  <= w_n1[1] * up_n1[2];
      cp[1]  <= w_n1[2] * up_n1[1];
      cp[2]  <= w_n1[2] * up_n1[0];
      cp[3]  <= w_n1[0] * up_n1[2];
      cp[4]  <= w_n1[0] * up_n1[1];
      cp[5]  <= w_n1[1] * up_n1[0];
      w_c1   <= w_n1;
      eye_c1 <= side1_out[S1W-1 -: 3*IN_W];
      for (int i = 0; i < 3; i++) begin
        t_c2[i] <= VEC_W'(cd[i]);
      end
      w_c2   <= w_c1;
      eye_c2 <= eye_c1;
    end
  end

  // Right vector.
  logic [S2W-1:0]       side2_in, side2_out;
  logic signed [UW-1:0] u_n2 [3];
  logic                 val_n2;

  assign side2_in = {eye_c2, w_c2[0], w_c2[1], w_c2[2]};

  lavm_norm #(.F(F), .SIDE_W(S2W)) u_norm_right (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(val_c2), .in_vec(t_c2), .in_side(side2_in),
    .out_valid(val_n2), .out_vec(u_n2), .out_side(side2_out)
  );

  logic signed [UW-1:0]   w_n2 [3];
  logic signed [IN_W-1:0] eye_n2 [3];
  assign w_n2[0]   = $signed(side2_out[3*UW-1 -: UW]);
  assign w_n2[1]   = $signed(side2_out[2*UW-1 -: UW]);
  assign w_n2[2]   = $signed(side2_out[UW-1 -: UW]);
  assign eye_n2[0] = $signed(side2_out[S2W-1 -: IN_W]);
  assign eye_n2[1] = $signed(side2_out[S2W-IN_W-1 -: IN_W]);
  assign eye_n2[2] = $signed(side2_out[S2W-2*IN_W-1 -: IN_W]);

  // True up = right x forward, then the three translation dot products.
  logic                   val_d1, val_d2, val_d3, val_d4, val_d5;
  logic signed [VW-1:0]   vp [6];
  logic signed [VW:0]     vd [3];
  logic signed [UW-1:0]   u_d1 [3], u_d2 [3], u_d3 [3], u_d4 [3];
  logic signed [UW-1:0]   v_d2 [3], v_d3 [3], v_d4 [3];
  logic signed [UW-1:0]   w_d1 [3], w_d2 [3], w_d3 [3], w_d4 [3];
  logic signed [IN_W-1:0] eye_d1 [3], eye_d2 [3];
  logic signed [PW-1:0]   tp [9];
  logic signed [VEC_W-1:0] ts [3];

  assign vd[0] = vp[0] - vp[1];
  assign vd[1] = vp[2] - vp[3];
  assign vd[2] = vp[4] - vp[5];

  always_ff @(posedge clk) begin
    if (en) begin
      vp[0]  <= u_n2[1] * w_n2[2];
      vp[1]  <= u_n2[2] * w_n2[1];
      vp[2]  <= u_n2[2] * w_n2[0];
      vp[3]  <= u_n2[0] * w_n2[2];
      vp[4]  <= u_n2[0] * w_n2[1];
      vp[5]  <= u_n2[1] * w_n2[0];
      u_d1   <= u_n2;
      w_d1   <= w_n2;
      eye_d1 <= eye_n2;
      for (int i = 0; i < 3; i++) begin
        v_d2[i] <= round_unit(vd[i]);
      end
      u_d2   <= u_d1;
      w_d2   <= w_d1;
      eye_d2 <= eye_d1;
      for (int i = 0; i < 3; i++) begin
        tp[i]     <= u_d2[i] * eye_d2[i];
        tp[3 + i] <= v_d2[i] * eye_d2[i];
        tp[6 + i] <= w_d2[i] * eye_d2[i];
      end
      u_d3 <= u_d2;
      v_d3 <= v_d2;
      w_d3 <= w_d2;
      for (int k = 0; k < 3; k++) begin
        ts[k] <= VEC_W'(tp[3*k]) + VEC_W'(tp[3*k+1]) + VEC_W'(tp[3*k+2]);
      end
      u_d4 <= u_d3;
      v_d4 <= v_d3;
      w_d4 <= w_d3;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      right_x       <= OUT_W'(u_d4[0]);
      right_y       <= OUT_W'(u_d4[1]);
      right_z       <= OUT_W'(u_d4[2]);
      camera_up_x   <= OUT_W'(v_d4[0]);
      camera_up_y   <= OUT_W'(v_d4[1]);
      camera_up_z   <= OUT_W'(v_d4[2]);
      forward_x     <= OUT_W'(w_d4[0]);
      forward_y     <= OUT_W'(w_d4[1]);
      forward_z     <= OUT_W'(w_d4[2]);
      shift_right   <= trans_fin(ts[0]);
      shift_up      <= trans_fin(ts[1]);
      shift_forward <= trans_fin(ts[2]);
    end
  end

  // Valid bits for the stages outside the normalizers.
  always_ff @(posedge clk) begin
    if (rst) begin
      val_c1 <= 1'b0;
      val_c2 <= 1'b0;
      val_d1 <= 1'b0;
      val_d2 <= 1'b0;
      val_d3 <= 1'b0;
      val_d4 <= 1'b0;
      val_d5 <= 1'b0;
    end else if (en) begin
      val_c1 <= val_n1;
      val_c2 <= val_c1;
      val_d1 <= val_n2;
      val_d2 <= val_d1;
      val_d3 <= val_d2;
      val_d4 <= val_d3;
      val_d5 <= val_d4;
    end
  end

  assign out_valid = val_d5;

  // A stalled result must hold back the input side.
  `LAVM_ASSERT_NOW(a_stall_backpressure, clk, rst, out_valid && out_stall, in_stall, "input accepted while output blocked")
  // A zero right vector leaves nothing to cross, so true up is zero too.
  `LAVM_ASSERT_NOW(a_zero_right_zero_up, clk, rst, val_d4 && u_d4[0] == 0 && u_d4[1] == 0 && u_d4[2] == 0, v_d4[0] == 0 && v_d4[1] == 0 && v_d4[2] == 0, "true up nonzero with zero right vector")
  // A zero forward vector gives a zero forward translation.
  `LAVM_ASSERT_NOW(a_zero_fwd_zero_shift, clk, rst, val_d4 && w_d4[0] == 0 && w_d4[1] == 0 && w_d4[2] == 0, ts[2] == 0, "forward translation nonzero with zero forward vector")
  // A result that is taken is followed by the next stage contents.
  `LAVM_ASSERT_NEXT(a_advance_moves, clk, rst, !out_stall && val_d4, out_valid, "pipeline lost a transaction")

endmodule
